// File: src/ogrsq_pkg.sv
// Shared constants for the occupancy grid rectangle stamp and query block.
// Holds request codes, configuration register indexes and datapath widths.
// No dependencies.
`default_nettype none

package ogrsq_pkg;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_STAMP  = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ORIGIN_X    = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_Z    = 2'd1;
    localparam logic [1:0] CFG_CELL_SIZE_X = 2'd2;
    localparam logic [1:0] CFG_CELL_SIZE_Z = 2'd3;

    localparam int CFG_IDX_W = 2;
    localparam int COORD_W   = 32;   // signed positions and origins
    localparam int SIZE_W    = 31;   // radii and cell sizes
    localparam int OFS_W     = 34;   // position -/+ radius - origin, signed
    localparam int MAG_W     = 33;   // magnitude of an offset
    localparam int QUO_W     = 8;    // quotient is kept modulo 256
    localparam int OUT_IDX_W = 6;    // width of the cell index output fields

endpackage

`default_nettype wire

// File: src/ogrsq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ogrsq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: src/ogrsq_div.sv
// Cell bound unit: a radix-2 restoring divider that turns a signed offset and a
// cell size into a saturated cell index. Depends on ogrsq_pkg.
`default_nettype none

module ogrsq_div #(
    parameter int GRID_CELLS = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [ogrsq_pkg::OFS_W-1:0] offset,
    input  wire logic [ogrsq_pkg::SIZE_W-1:0]      divisor,
    output logic                                   done,
    output logic [$clog2(GRID_CELLS)-1:0]          idx
);

    localparam int IDX_W = $clog2(GRID_CELLS);
    localparam int CNT_W = $clog2(ogrsq_pkg::MAG_W + 1);
    localparam int MAG_W = ogrsq_pkg::MAG_W;
    localparam int SIZE_W = ogrsq_pkg::SIZE_W;
    localparam int QUO_W = ogrsq_pkg::QUO_W;
    localparam logic [QUO_W-1:0] LIMIT = QUO_W'(GRID_CELLS - 1);

    logic                 busy_reg,  busy_next;
    logic                 fin_reg,   fin_next;
    logic                 done_reg,  done_next;
    logic [CNT_W-1:0]     cnt_reg,   cnt_next;
    logic [MAG_W-1:0]     num_reg,   num_next;
    logic [SIZE_W-1:0]    rem_reg,   rem_next;
    logic [QUO_W-1:0]     quo_reg,   quo_next;
    logic                 neg_reg,   neg_next;
    logic                 zero_reg,  zero_next;
    logic [IDX_W-1:0]     idx_reg,   idx_next;

    logic [ogrsq_pkg::OFS_W-1:0] abs_ofs;
    logic [SIZE_W:0]             shifted;
    logic                        fits;
    logic [QUO_W-1:0]            quo_signed;

    always_comb
    begin
        abs_ofs    = offset[ogrsq_pkg::OFS_W-1] ? (~offset + 1'b1) : offset;
        shifted    = {rem_reg, num_reg[MAG_W-1]};
        fits       = shifted >= {1'b0, divisor};
        quo_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        idx_next  = idx_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MAG_W);
            num_next  = abs_ofs[MAG_W-1:0];
            rem_next  = '0;
            quo_next  = '0;
            neg_next  = offset[ogrsq_pkg::OFS_W-1];
            zero_next = (offset == '0) || (divisor == '0);
        end
        else if (busy_reg)
        begin
            // One quotient bit per cycle; only the low bits are kept.
            rem_next = fits ? SIZE_W'(shifted - {1'b0, divisor}) : shifted[SIZE_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], fits};
            num_next = {num_reg[MAG_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end

        if (fin_reg)
        begin
            // A negative quotient wraps modulo 256; a wrapped byte above the limit saturates.
            done_next = 1'b1;
            if (zero_reg)
            begin
                idx_next = '0;
            end
            else if (quo_signed > LIMIT)
            begin
                idx_next = LIMIT[IDX_W-1:0];
            end
            else
            begin
                idx_next = quo_signed[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        idx_reg  <= idx_next;
    end

    assign done = done_reg;
    assign idx  = idx_reg;

endmodule

`default_nettype wire

// File: src/occupancy_grid_rect_stamp_query.sv
// Occupancy grid with rectangle stamp and query: a GRID_CELLS by GRID_CELLS
// bitmap, one word per X column, held in a RAM with a registered read.
// Depends on ogrsq_pkg, ogrsq_div and ogrsq_ram.
//
// The block takes one request word at a time and gives one result word for
// each. A clear or an unused request code goes straight to the result state;
// the clear empties the whole bitmap at once through per-column valid bits, so
// reset needs no clearing pass. A stamp or query first finds the four cell
// bounds in parallel with 33-step bit-serial dividers, then walks over the
// covered columns with a read-modify-write through the single RAM read port.
// A new request word is taken as soon as the previous result sits in the
// output register, even while that result is still stalled.
`default_nettype none

module occupancy_grid_rect_stamp_query #(
    parameter int GRID_CELLS = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 cfg_we,
    input  wire logic [ogrsq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ogrsq_pkg::COORD_W-1:0]        cfg_wdata,

    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [1:0]                           req_type,
    input  wire logic signed [ogrsq_pkg::COORD_W-1:0] pos_x,
    input  wire logic signed [ogrsq_pkg::COORD_W-1:0] pos_z,
    input  wire logic [ogrsq_pkg::SIZE_W-1:0]         half_x,
    input  wire logic [ogrsq_pkg::SIZE_W-1:0]         half_z,

    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      hit,
    output logic [ogrsq_pkg::OUT_IDX_W-1:0]           cell_lo_x,
    output logic [ogrsq_pkg::OUT_IDX_W-1:0]           cell_lo_z,
    output logic [ogrsq_pkg::OUT_IDX_W-1:0]           cell_hi_x,
    output logic [ogrsq_pkg::OUT_IDX_W-1:0]           cell_hi_z
);

    localparam int IDX_W   = $clog2(GRID_CELLS);
    localparam int COORD_W = ogrsq_pkg::COORD_W;
    localparam int SIZE_W  = ogrsq_pkg::SIZE_W;
    localparam int OFS_W   = ogrsq_pkg::OFS_W;
    localparam int OUT_W   = ogrsq_pkg::OUT_IDX_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_OFS   = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]                 state_reg, state_next;

    logic signed [COORD_W-1:0]  origin_x_reg, origin_z_reg;
    logic [SIZE_W-1:0]          cell_size_x_reg, cell_size_z_reg;

    logic [1:0]                 req_reg;
    logic signed [COORD_W-1:0]  pos_x_reg, pos_z_reg;
    logic [SIZE_W-1:0]          half_x_reg, half_z_reg;

    logic signed [OFS_W-1:0]    ofs_lo_x_reg, ofs_hi_x_reg, ofs_lo_z_reg, ofs_hi_z_reg;
    logic signed [OFS_W-1:0]    ofs_lo_x_next, ofs_hi_x_next, ofs_lo_z_next, ofs_hi_z_next;

    logic [IDX_W-1:0]           x_reg, x_next;
    logic [GRID_CELLS-1:0]      mask_reg, mask_next;
    logic [GRID_CELLS-1:0]      valid_reg, valid_next;
    logic                       rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]           rd_addr_reg, rd_addr_next;
    logic                       rvld_reg, rvld_next;
    logic                       hit_reg, hit_next;

    logic                       out_valid_reg, out_valid_next;
    logic                       out_hit_reg;
    logic [OUT_W-1:0]           out_lo_x_reg, out_lo_z_reg, out_hi_x_reg, out_hi_z_reg;
    logic                       out_load;

    logic                       div_start;
    logic                       done_lo_x, done_hi_x, done_lo_z, done_hi_z;
    logic [IDX_W-1:0]           lo_x, hi_x, lo_z, hi_z;

    logic                       ram_we;
    logic [GRID_CELLS-1:0]      ram_wdata, ram_rdata, word;
    logic [IDX_W-1:0]           ram_raddr;

    logic                       in_accept;
    logic                       is_rect;
    logic [GRID_CELLS-1:0]      row_mask;

    logic signed [OFS_W-1:0]    px_ext, pz_ext, ox_ext, oz_ext;
    logic signed [OFS_W-1:0]    hx_ext, hz_ext;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign div_start = (state_reg == S_START);
    assign is_rect   = (req_reg == ogrsq_pkg::REQ_STAMP) || (req_reg == ogrsq_pkg::REQ_QUERY);

    ogrsq_div #(.GRID_CELLS(GRID_CELLS)) u_div_lo_x (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .offset(ofs_lo_x_reg), .divisor(cell_size_x_reg), .done(done_lo_x), .idx(lo_x)
    );
    ogrsq_div #(.GRID_CELLS(GRID_CELLS)) u_div_hi_x (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .offset(ofs_hi_x_reg), .divisor(cell_size_x_reg), .done(done_hi_x), .idx(hi_x)
    );
    ogrsq_div #(.GRID_CELLS(GRID_CELLS)) u_div_lo_z (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .offset(ofs_lo_z_reg), .divisor(cell_size_z_reg), .done(done_lo_z), .idx(lo_z)
    );
    ogrsq_div #(.GRID_CELLS(GRID_CELLS)) u_div_hi_z (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .offset(ofs_hi_z_reg), .divisor(cell_size_z_reg), .done(done_hi_z), .idx(hi_z)
    );

    // Columns are visited in strictly increasing order, so a write never meets
    // a read of the same column and no forwarding is needed.
    ogrsq_ram #(.WIDTH(GRID_CELLS), .DEPTH(GRID_CELLS)) u_bitmap (
        .clk(clk), .we(ram_we), .waddr(rd_addr_reg), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    always_comb
    begin
        px_ext = OFS_W'(pos_x_reg);
        pz_ext = OFS_W'(pos_z_reg);
        ox_ext = OFS_W'(origin_x_reg);
        oz_ext = OFS_W'(origin_z_reg);
        hx_ext = OFS_W'({1'b0, half_x_reg});
        hz_ext = OFS_W'({1'b0, half_z_reg});

        ofs_lo_x_next = px_ext - hx_ext - ox_ext;
        ofs_hi_x_next = px_ext + hx_ext - ox_ext;
        ofs_lo_z_next = pz_ext - hz_ext - oz_ext;
        ofs_hi_z_next = pz_ext + hz_ext - oz_ext;

        for (int i = 0; i < GRID_CELLS; i++)
        begin
            row_mask[i] = (IDX_W'(i) >= lo_z) && (IDX_W'(i) <= hi_z);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        x_next       = x_reg;
        mask_next    = mask_reg;
        valid_next   = valid_reg;
        rd_pend_next = 1'b0;
        rd_addr_next = rd_addr_reg;
        rvld_next    = rvld_reg;
        hit_next     = hit_reg;
        out_load     = 1'b0;
        ram_raddr    = x_reg;

        // Second half of the read-modify-write: the word read last cycle.
        // A column never written since the last clear reads as empty.
        word      = rvld_reg ? ram_rdata : '0;
        ram_wdata = word | mask_reg;
        ram_we    = rd_pend_reg && (req_reg == ogrsq_pkg::REQ_STAMP);
        if (ram_we)
        begin
            valid_next[rd_addr_reg] = 1'b1;
        end
        if (rd_pend_reg && (req_reg == ogrsq_pkg::REQ_QUERY) && ((word & mask_reg) != '0))
        begin
            hit_next = 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    hit_next = 1'b0;
                    priority if (req_type == ogrsq_pkg::REQ_CLEAR)
                    begin
                        valid_next = '0;
                        state_next = S_DONE;
                    end
                    else if (req_type == ogrsq_pkg::REQ_UNUSED)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_OFS;
                    end
                end
            end
            S_OFS:
            begin
                state_next = S_START;
            end
            S_START:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (done_lo_x && done_hi_x && done_lo_z && done_hi_z)
                begin
                    mask_next = row_mask;
                    x_next    = lo_x;
                    if ((lo_x <= hi_x) && (lo_z <= hi_z))
                    begin
                        state_next = S_WALK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_WALK:
            begin
                rd_pend_next = 1'b1;
                rd_addr_next = x_reg;
                rvld_next    = valid_reg[x_reg];
                x_next       = x_reg + 1'b1;
                if (x_reg == hi_x)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = (out_valid_reg && out_stall) || out_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            valid_reg       <= '0;
            rd_pend_reg     <= 1'b0;
            hit_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            origin_x_reg    <= '0;
            origin_z_reg    <= '0;
            cell_size_x_reg <= '0;
            cell_size_z_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            rd_pend_reg   <= rd_pend_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ogrsq_pkg::CFG_ORIGIN_X:    origin_x_reg    <= cfg_wdata;
                    ogrsq_pkg::CFG_ORIGIN_Z:    origin_z_reg    <= cfg_wdata;
                    ogrsq_pkg::CFG_CELL_SIZE_X: cell_size_x_reg <= cfg_wdata[SIZE_W-1:0];
                    ogrsq_pkg::CFG_CELL_SIZE_Z: cell_size_z_reg <= cfg_wdata[SIZE_W-1:0];
                    default:                    origin_x_reg    <= origin_x_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg    <= req_type;
            pos_x_reg  <= pos_x;
            pos_z_reg  <= pos_z;
            half_x_reg <= half_x;
            half_z_reg <= half_z;
        end
        if (state_reg == S_OFS)
        begin
            ofs_lo_x_reg <= ofs_lo_x_next;
            ofs_hi_x_reg <= ofs_hi_x_next;
            ofs_lo_z_reg <= ofs_lo_z_next;
            ofs_hi_z_reg <= ofs_hi_z_next;
        end
        x_reg       <= x_next;
        mask_reg    <= mask_next;
        rd_addr_reg <= rd_addr_next;
        rvld_reg    <= rvld_next;
        if (out_load)
        begin
            out_hit_reg  <= (req_reg == ogrsq_pkg::REQ_QUERY) && hit_reg;
            out_lo_x_reg <= is_rect ? OUT_W'(lo_x) : '0;
            out_lo_z_reg <= is_rect ? OUT_W'(lo_z) : '0;
            out_hi_x_reg <= is_rect ? OUT_W'(hi_x) : '0;
            out_hi_z_reg <= is_rect ? OUT_W'(hi_z) : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = out_hit_reg;
    assign cell_lo_x = out_lo_x_reg;
    assign cell_lo_z = out_lo_z_reg;
    assign cell_hi_x = out_hi_x_reg;
    assign cell_hi_z = out_hi_z_reg;

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for occupancy_grid_rect_stamp_query.
// Mirrors the occupancy bitmap and the cell bound arithmetic in SystemVerilog and
// checks every result word. Depends on ogrsq_pkg and the block under test.

module tb_top;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int NUM_PHASES  = 7;

    typedef struct {
        logic [1:0]          kind;
        logic signed [31:0]  px;
        logic signed [31:0]  pz;
        logic [30:0]         hx;
        logic [30:0]         hz;
    } grid_req_t;

    typedef struct {
        logic       hit;
        logic [5:0] lo_x;
        logic [5:0] lo_z;
        logic [5:0] hi_x;
        logic [5:0] hi_z;
    } cell_span_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [ogrsq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ogrsq_pkg::COORD_W-1:0]   cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = ogrsq_pkg::REQ_CLEAR;
    logic signed [ogrsq_pkg::COORD_W-1:0] pos_x = '0;
    logic signed [ogrsq_pkg::COORD_W-1:0] pos_z = '0;
    logic [ogrsq_pkg::SIZE_W-1:0] half_x = '0;
    logic [ogrsq_pkg::SIZE_W-1:0] half_z = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        hit;
    logic [ogrsq_pkg::OUT_IDX_W-1:0] cell_lo_x;
    logic [ogrsq_pkg::OUT_IDX_W-1:0] cell_lo_z;
    logic [ogrsq_pkg::OUT_IDX_W-1:0] cell_hi_x;
    logic [ogrsq_pkg::OUT_IDX_W-1:0] cell_hi_z;

    // Shadow copy of the bitmap and the configuration registers.
    bit [63:0]          occ_map [64];
    logic signed [31:0] org_x = '0;
    logic signed [31:0] org_z = '0;
    logic [30:0]        csz_x = '0;
    logic [30:0]        csz_z = '0;

    grid_req_t   grid_reqs_waiting [$];
    cell_span_t  predicted_spans [$];
    bit          in_fire = 1'b0;
    int          send_idle_pct = 29;
    int          recv_idle_pct = 68;
    int unsigned mismatches = 0;
    int unsigned spans_checked = 0;
    int unsigned query_hits = 0;
    int unsigned cycle_count = 0;

    occupancy_grid_rect_stamp_query uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .pos_x     (pos_x),
        .pos_z     (pos_z),
        .half_x    (half_x),
        .half_z    (half_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit),
        .cell_lo_x (cell_lo_x),
        .cell_lo_z (cell_lo_z),
        .cell_hi_x (cell_hi_x),
        .cell_hi_z (cell_hi_z)
    );

    always #5 clk = ~clk;

    // Truncating divide, keep the low 8 bits of the quotient, saturate to 63.
    function automatic logic [5:0] cell_bound(longint ofs, longint csize);
        longint     quo;
        logic [7:0] wrapped;
        if (ofs == 0 || csize == 0)
            return '0;
        quo = ofs / csize;
        wrapped = quo[7:0];
        return (wrapped > 8'd63) ? 6'd63 : wrapped[5:0];
    endfunction

    function automatic cell_span_t grid_predict(grid_req_t r);
        cell_span_t span;
        bit [63:0]  rows;
        int         x;
        int         z;
        span = '{hit: 1'b0, lo_x: '0, lo_z: '0, hi_x: '0, hi_z: '0};
        if (r.kind == ogrsq_pkg::REQ_CLEAR)
        begin
            occ_map = '{default: '0};
            return span;
        end
        if (r.kind == ogrsq_pkg::REQ_UNUSED)
            return span;
        span.lo_x = cell_bound(longint'(r.px) - longint'(r.hx) - longint'(org_x),
                               longint'(csz_x));
        span.hi_x = cell_bound(longint'(r.hx) + longint'(r.px) - longint'(org_x),
                               longint'(csz_x));
        span.lo_z = cell_bound(longint'(r.pz) - longint'(r.hz) - longint'(org_z),
                               longint'(csz_z));
        span.hi_z = cell_bound(longint'(r.hz) + longint'(r.pz) - longint'(org_z),
                               longint'(csz_z));
        if (span.lo_x <= span.hi_x && span.lo_z <= span.hi_z)
        begin
            rows = '0;
            for (z = span.lo_z; z <= span.hi_z; z++)
                rows[z] = 1'b1;
            for (x = span.lo_x; x <= span.hi_x; x++)
            begin
                if (r.kind == ogrsq_pkg::REQ_STAMP)
                    occ_map[x] |= rows;
                else if ((occ_map[x] & rows) != '0)
                    span.hit = 1'b1;
            end
        end
        return span;
    endfunction

    // Mostly rectangles placed on the current grid, with some noise words.
    function automatic grid_req_t make_random_req();
        grid_req_t   r;
        int unsigned sel;
        longint      cx;
        longint      cz;
        sel = $urandom_range(99);
        cx = (csz_x == 0) ? 256 : longint'(csz_x);
        cz = (csz_z == 0) ? 256 : longint'(csz_z);
        r.kind = ogrsq_pkg::REQ_CLEAR;
        r.px = $urandom;
        r.pz = $urandom;
        r.hx = 31'($urandom);
        r.hz = 31'($urandom);
        if (sel < 5)
            r.kind = ogrsq_pkg::REQ_CLEAR;
        else if (sel < 8)
            r.kind = ogrsq_pkg::REQ_UNUSED;
        else
        begin
            r.kind = ($urandom_range(1) == 0) ? ogrsq_pkg::REQ_STAMP : ogrsq_pkg::REQ_QUERY;
            if (sel >= 18)
            begin
                r.px = 32'(longint'(org_x)
                           + (longint'($urandom_range(72 * 256)) - 1024) * cx / 256);
                r.pz = 32'(longint'(org_z)
                           + (longint'($urandom_range(72 * 256)) - 1024) * cz / 256);
                if ($urandom_range(9) != 0)
                begin
                    r.hx = 31'(longint'($urandom_range(5 * 256)) * cx / 256);
                    r.hz = 31'(longint'($urandom_range(5 * 256)) * cz / 256);
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Monitor: configuration shadow, input words into the predictor, result checks.
    always @(posedge clk)
    begin
        cell_span_t want;
        grid_req_t  seen;
        if (cfg_we)
        begin
            case (cfg_index)
                ogrsq_pkg::CFG_ORIGIN_X:    org_x = cfg_wdata;
                ogrsq_pkg::CFG_ORIGIN_Z:    org_z = cfg_wdata;
                ogrsq_pkg::CFG_CELL_SIZE_X: csz_x = cfg_wdata[30:0];
                ogrsq_pkg::CFG_CELL_SIZE_Z: csz_z = cfg_wdata[30:0];
                default: ;
            endcase
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_spans.size() == 0)
            begin
                $error("result word with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = predicted_spans.pop_front();
                check_field("hit", want.hit, hit);
                check_field("cell_lo_x", want.lo_x, cell_lo_x);
                check_field("cell_lo_z", want.lo_z, cell_lo_z);
                check_field("cell_hi_x", want.hi_x, cell_hi_x);
                check_field("cell_hi_z", want.hi_z, cell_hi_z);
                spans_checked++;
                if (hit)
                    query_hits++;
            end
        end
        in_fire = rst_n && in_valid && !in_stall;
        if (in_fire)
        begin
            seen.kind = req_type;
            seen.px = pos_x;
            seen.pz = pos_z;
            seen.hx = half_x;
            seen.hz = half_z;
            predicted_spans.push_back(grid_predict(seen));
        end
    end

    // Request driver: holds a stalled word, otherwise presents the next one or idles.
    always @(negedge clk)
    begin
        grid_req_t nxt;
        if (rst_n && (!in_valid || in_fire))
        begin
            if (grid_reqs_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = grid_reqs_waiting.pop_front();
                req_type <= nxt.kind;
                pos_x <= nxt.px;
                pos_z <= nxt.pz;
                half_x <= nxt.hx;
                half_z <= nxt.hz;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
        out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(logic [ogrsq_pkg::CFG_IDX_W-1:0] idx,
                             logic [ogrsq_pkg::COORD_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_req(logic [1:0] kind, logic signed [31:0] px,
                             logic signed [31:0] pz, logic [30:0] hx, logic [30:0] hz);
        grid_req_t r;
        r.kind = kind;
        r.px = px;
        r.pz = pz;
        r.hx = hx;
        r.hz = hz;
        grid_reqs_waiting.push_back(r);
    endtask

    // Sampled just after a rising edge, once the monitor has run.
    task automatic wait_drained();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (grid_reqs_waiting.size() != 0 || (in_valid && !in_fire)
               || predicted_spans.size() != 0);
    endtask

    initial
    begin
        int phase;
        int k;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase * 3 / NUM_PHASES)
                0:       begin send_idle_pct = 29; recv_idle_pct = 68; end
                1:       begin send_idle_pct = 68; recv_idle_pct = 29; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            // Phase 0 runs on the reset values, where every bound is zero.
            case (phase)
                0: ;
                1:
                begin
                    write_reg(ogrsq_pkg::CFG_ORIGIN_X, -32'sd8192);
                    write_reg(ogrsq_pkg::CFG_ORIGIN_Z, 32'sd5000);
                    write_reg(ogrsq_pkg::CFG_CELL_SIZE_X, 32'd256);
                    write_reg(ogrsq_pkg::CFG_CELL_SIZE_Z, 32'd384);
                end
                2:
                begin
                    write_reg(ogrsq_pkg::CFG_ORIGIN_X, 32'h8000_0000);
                    write_reg(ogrsq_pkg::CFG_ORIGIN_Z, 32'h7FFF_FFFF);
                    write_reg(ogrsq_pkg::CFG_CELL_SIZE_X, 32'h7FFF_FFFF);
                    write_reg(ogrsq_pkg::CFG_CELL_SIZE_Z, 32'd1);
                end
                3:
                begin
                    write_reg(ogrsq_pkg::CFG_ORIGIN_X, $urandom);
                    write_reg(ogrsq_pkg::CFG_ORIGIN_Z, $urandom);
                    write_reg(ogrsq_pkg::CFG_CELL_SIZE_X, 32'd0);
                    write_reg(ogrsq_pkg::CFG_CELL_SIZE_Z, 32'd0);
                end
                4:
                begin
                    write_reg(ogrsq_pkg::CFG_ORIGIN_X, $urandom);
                    write_reg(ogrsq_pkg::CFG_ORIGIN_Z, $urandom);
                    write_reg(ogrsq_pkg::CFG_CELL_SIZE_X, $urandom_range(1, 4096));
                    write_reg(ogrsq_pkg::CFG_CELL_SIZE_Z, $urandom_range(1, 4096));
                end
                default:
                begin
                    write_reg(ogrsq_pkg::CFG_ORIGIN_X,
                              $urandom_range(32'h00FF_FFFF) - 32'h0080_0000);
                    write_reg(ogrsq_pkg::CFG_ORIGIN_Z,
                              $urandom_range(32'h00FF_FFFF) - 32'h0080_0000);
                    write_reg(ogrsq_pkg::CFG_CELL_SIZE_X,
                              $urandom_range(1, (phase == 5) ? 4096 : 64));
                    write_reg(ogrsq_pkg::CFG_CELL_SIZE_Z,
                              $urandom_range(1, (phase == 5) ? 4096 : 64));
                end
            endcase
            if (phase == 1)
            begin
                // Cells are 256 wide in X from -8192 and 384 deep in Z from 5000.
                queue_req(ogrsq_pkg::REQ_CLEAR, 0, 0, 0, 0);
                queue_req(ogrsq_pkg::REQ_QUERY, 128, 17480, 8192, 12288);
                queue_req(ogrsq_pkg::REQ_STAMP, -5504, 12872, 0, 0);
                queue_req(ogrsq_pkg::REQ_QUERY, -5504, 12872, 0, 0);
                queue_req(ogrsq_pkg::REQ_QUERY, -5248, 12872, 0, 0);
                queue_req(ogrsq_pkg::REQ_STAMP, -8092, 12872, 0, 0);
                // Negative low offset wraps to column 63, above the high bound.
                queue_req(ogrsq_pkg::REQ_QUERY, -8192, 12872, 256, 0);
                // A small negative offset truncates toward zero, onto column 0.
                queue_req(ogrsq_pkg::REQ_QUERY, -8292, 12872, 0, 0);
                queue_req(ogrsq_pkg::REQ_STAMP, -8192, 5000, 0, 0);
                queue_req(ogrsq_pkg::REQ_STAMP, 32'h7FFF_FFFF, 32'h8000_0000,
                          31'h7FFF_FFFF, 31'h7FFF_FFFF);
                queue_req(ogrsq_pkg::REQ_QUERY, 32'h8000_0000, 32'h7FFF_FFFF,
                          0, 31'h7FFF_FFFF);
                queue_req(ogrsq_pkg::REQ_UNUSED, 32'h1234_5678, -32'sd77,
                          31'h2AAA_AAAA, 31'h5555);
                queue_req(ogrsq_pkg::REQ_STAMP, 128, 17480, 8192, 12288);
                queue_req(ogrsq_pkg::REQ_QUERY, 8064, 29384, 0, 0);
                queue_req(ogrsq_pkg::REQ_CLEAR, -32'sd1, -32'sd1,
                          31'h7FFF_FFFF, 31'h7FFF_FFFF);
                queue_req(ogrsq_pkg::REQ_QUERY, 128, 17480, 8192, 12288);
                queue_req(ogrsq_pkg::REQ_UNUSED, -32'sd1, -32'sd1,
                          31'h7FFF_FFFF, 31'h7FFF_FFFF);
                queue_req(ogrsq_pkg::REQ_QUERY, -8064, 5192, 0, 0);
            end
            for (k = 0; k < ((phase == 0) ? 20 : 160); k++)
                grid_reqs_waiting.push_back(make_random_req());
            // Sender holds off here until every result of the phase is back.
            wait_drained();
        end
        repeat (300) @(posedge clk);
        $display("Checked %0d result words across %0d register settings, %0d query hits.",
                 spans_checked, NUM_PHASES, query_hits);
        $display("Stimulus mixed clears, stamps, queries and unused codes under varied stalls.");
        if (mismatches == 0 && predicted_spans.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
